FILE: src/pdgb_pkg.sv
// Shared types and constants for the particle density grid binning unit.
// Holds payload structs, config registers, queue entry and status codes.
// No dependencies.
`timescale 1ns / 1ps

package pdgb_pkg;

  localparam int MAX_CELLS_PER_SIDE_DEF = 16;
  localparam int COUNT_WIDTH_DEF        = 16;

  localparam int IDX_W     = 12;  // cell_index field width
  localparam int QDEPTH    = 2;   // front-to-back queue depth
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CELLS_PER_SIDE = 3'd0,
    REG_INV_CELL_SIZE  = 3'd1,
    REG_ORIGIN_X       = 3'd2,
    REG_ORIGIN_Y       = 3'd3,
    REG_ORIGIN_Z       = 3'd4,
    REG_CELL_WEIGHT    = 3'd5,
    REG_ROW_STRIDE     = 3'd6,
    REG_PLANE_STRIDE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_ADD  = 2'd0,
    CLS_DROP = 2'd1,
    CLS_READ = 2'd2
  } cls_t;

  typedef struct packed {
    logic [4:0]         cells_per_side;
    logic [23:0]        inv_cell_size;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        cell_weight;
    logic [15:0]        row_stride;
    logic [31:0]        plane_stride;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [IDX_W-1:0]   cell_index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] global_index;
    logic [47:0] density;
  } out_item_t;

  typedef struct packed {
    cls_t             cls;
    logic [31:0]      dist_x;
    logic [31:0]      dist_y;
    logic [31:0]      dist_z;
    logic [IDX_W-1:0] cell_index;
  } entry_t;

endpackage

FILE: src/pdgb_front.sv
// Front end: accepts input beats, subtracts the grid origin and classifies.
// Depends on pdgb_pkg; feeds pdgb_queue.
`timescale 1ns / 1ps

module pdgb_front (
  input  pdgb_pkg::in_item_t in_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdgb_pkg::cfg_t     cfg,
  input  logic               full,
  input  logic               clearing,
  output logic               push,
  output pdgb_pkg::entry_t   entry
);
  import pdgb_pkg::*;

  logic [32:0] dx, dy, dz;

  assign dx = {in_data.pos_x[31], in_data.pos_x} - {cfg.origin_x[31], cfg.origin_x};
  assign dy = {in_data.pos_y[31], in_data.pos_y} - {cfg.origin_y[31], cfg.origin_y};
  assign dz = {in_data.pos_z[31], in_data.pos_z} - {cfg.origin_z[31], cfg.origin_z};

  assign in_stall = full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    entry.dist_x     = dx[31:0];
    entry.dist_y     = dy[31:0];
    entry.dist_z     = dz[31:0];
    entry.cell_index = in_data.cell_index;
    if (in_data.op) begin
      entry.cls = CLS_READ;
    end else if (dx[32] | dy[32] | dz[32]) begin
      // below the origin on some axis
      entry.cls = CLS_DROP;
    end else begin
      entry.cls = CLS_ADD;
    end
  end

endmodule

FILE: src/pdgb_queue.sv
// Short queue between front and back so each side stalls on its own.
// Depends on pdgb_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pdgb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pdgb_pkg::entry_t entry_in,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output pdgb_pkg::entry_t head
);
  import pdgb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);

  entry_t          slots [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNW-1:0]  count;

  assign full      = (count == CNW'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

FILE: src/pdgb_div.sv
// Restoring divider, one quotient bit per cycle, for cell index decomposition.
// Depends on pdgb_pkg for the index width.
`timescale 1ns / 1ps

module pdgb_div #(
  parameter int SW = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pdgb_pkg::IDX_W-1:0] dividend,
  input  logic [SW-1:0]             divisor,
  output logic                      busy,
  output logic                      done,
  output logic [pdgb_pkg::IDX_W-1:0] quotient,
  output logic [SW-1:0]             remainder
);
  import pdgb_pkg::*;

  localparam int CNTW = $clog2(IDX_W);

  logic [SW-1:0]    dvs;
  logic [CNTW-1:0]  cnt;
  logic [SW:0]      trial;
  logic [SW:0]      diff;
  logic             ge;

  assign trial = {remainder, quotient[IDX_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[SW-1:0] : trial[SW-1:0];
      quotient  <= {quotient[IDX_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(IDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/pdgb_back.sv
// Back end: sequencer with one shared multiplier, counter memory and result register.
// Depends on pdgb_pkg and pdgb_div; takes work from pdgb_queue.
`timescale 1ns / 1ps

module pdgb_back #(
  parameter int MAX_SIDE = pdgb_pkg::MAX_CELLS_PER_SIDE_DEF,
  parameter int COUNT_W  = pdgb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pdgb_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  pdgb_pkg::entry_t    q_entry,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output pdgb_pkg::out_item_t out_data
);
  import pdgb_pkg::*;

  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int CW     = $clog2(MAX_SIDE);
  localparam int NCELLS = MAX_SIDE ** 3;
  localparam int AW     = $clog2(NCELLS);
  localparam int XW     = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_AMUL  = 17'h00004,
    S_ACHK  = 17'h00008,
    S_ARD   = 17'h00010,
    S_AWR   = 17'h00020,
    S_D1S   = 17'h00040,
    S_D1W   = 17'h00080,
    S_D2S   = 17'h00100,
    S_D2W   = 17'h00200,
    S_GMUL  = 17'h00400,
    S_GADD  = 17'h00800,
    S_SMUL  = 17'h01000,
    S_SADD  = 17'h02000,
    S_WMUL  = 17'h04000,
    S_WSAT  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] mem [NCELLS];
  logic [COUNT_W-1:0] rdata;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [COUNT_W-1:0] mem_wdata;
  logic [AW-1:0]      clr_addr;

  logic [31:0]        delta [3];
  logic [IDX_W-1:0]   cidx;
  logic [XW-1:0]      cidx_ext;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      acc;
  logic [AW+SW-1:0]   hprod;
  logic [AW-1:0]      acc_next;
  logic [1:0]         axis;
  logic [63:0]        prod;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        coord;
  logic [SW-1:0]      side;
  logic [SW-1:0]      lx, ly;
  logic [IDX_W-1:0]   q1;
  logic [IDX_W-1:0]   lz;
  logic [31:0]        lsel;
  logic [31:0]        orgsel;
  logic [31:0]        mag;
  logic [31:0]        off;
  logic [31:0]        gsum;
  logic [31:0]        gacc;
  logic [31:0]        term;
  logic [47:0]        dens;
  status_t            st;
  logic               out_load;

  logic               div_start;
  logic [IDX_W-1:0]   div_dividend;
  logic               div_busy;
  logic               div_done;
  logic [IDX_W-1:0]   div_quo;
  logic [SW-1:0]      div_rem;

  // Clamp the side to the supported range.
  always_comb begin
    if (cfg.cells_per_side == '0) begin
      side = SW'(1);
    end else if (32'(cfg.cells_per_side) > 32'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(cfg.cells_per_side);
    end
  end

  assign cidx_ext = XW'(q_entry.cell_index);
  assign coord    = prod[63:32];
  assign hprod    = acc * side;
  assign acc_next = hprod[AW-1:0] + AW'(coord[CW-1:0]);

  assign clearing  = (state == S_CLEAR);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign div_start = (state == S_D1S) || (state == S_D2S);
  assign div_dividend = (state == S_D1S) ? cidx : q1;

  pdgb_div #(.SW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (side),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Per-axis selection for the global offset steps.
  always_comb begin
    case (axis)
      2'd0: begin
        orgsel = cfg.origin_x;
        lsel   = 32'(lx);
      end
      2'd1: begin
        orgsel = cfg.origin_y;
        lsel   = 32'(ly);
      end
      default: begin
        orgsel = cfg.origin_z;
        lsel   = 32'(lz);
      end
    endcase
    mag  = orgsel[31] ? (~orgsel + 32'd1) : orgsel;
    off  = orgsel[31] ? (32'd0 - coord) : coord;
    gsum = lsel + off;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (state)
      S_AMUL: begin
        mul_a = delta[axis];
        mul_b = 32'(cfg.inv_cell_size);
      end
      S_GMUL: begin
        mul_a = mag;
        mul_b = 32'(cfg.inv_cell_size);
      end
      S_SMUL: begin
        mul_a = term;
        mul_b = (axis == 2'd1) ? 32'(cfg.row_stride) : cfg.plane_stride;
      end
      S_WMUL: begin
        mul_a = 32'(rdata);
        mul_b = cfg.cell_weight;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Counter memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_ARD: mem_re = 1'b1;
      S_AWR: begin
        mem_we    = 1'b1;
        mem_wdata = (&rdata) ? rdata : rdata + COUNT_W'(1);
      end
      S_D1S: mem_re = 1'b1;
      S_WSAT: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == AW'(NCELLS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          case (q_entry.cls)
            CLS_ADD:  state_next = S_AMUL;
            CLS_READ: state_next = S_D1S;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_AMUL: state_next = S_ACHK;
      S_ACHK: begin
        if (coord >= 32'(side)) begin
          state_next = S_DONE;
        end else if (axis == 2'd0) begin
          state_next = S_ARD;
        end else begin
          state_next = S_AMUL;
        end
      end
      S_ARD: state_next = S_AWR;
      S_AWR: state_next = S_DONE;
      S_D1S: state_next = S_D1W;
      S_D1W: if (div_done) state_next = S_D2S;
      S_D2S: state_next = S_D2W;
      S_D2W: begin
        if (div_done) begin
          state_next = (32'(div_quo) >= 32'(side)) ? S_DONE : S_GMUL;
        end
      end
      S_GMUL: state_next = S_GADD;
      S_GADD: state_next = (axis == 2'd0) ? S_GMUL : S_SMUL;
      S_SMUL: state_next = S_SADD;
      S_SADD: state_next = (axis == 2'd2) ? S_WMUL : S_GMUL;
      S_WMUL: state_next = S_WSAT;
      S_WSAT: state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        delta[0] <= q_entry.dist_x;
        delta[1] <= q_entry.dist_y;
        delta[2] <= q_entry.dist_z;
        cidx     <= q_entry.cell_index;
        addr     <= cidx_ext[AW-1:0];
        acc      <= '0;
        gacc     <= '0;
        dens     <= '0;
        case (q_entry.cls)
          CLS_ADD: begin
            axis <= 2'd2;
            st   <= ST_COUNTED;
          end
          CLS_READ: begin
            axis <= 2'd0;
            st   <= ST_READ;
          end
          default: begin
            axis <= 2'd0;
            st   <= ST_DROPPED;
          end
        endcase
      end
      S_ACHK: begin
        if (coord >= 32'(side)) begin
          st <= ST_DROPPED;
        end else begin
          acc  <= acc_next;
          addr <= acc_next;
          axis <= axis - 2'd1;
        end
      end
      S_D1W: begin
        if (div_done) begin
          lx <= div_rem;
          q1 <= div_quo;
        end
      end
      S_D2W: begin
        if (div_done) begin
          ly <= div_rem;
          lz <= div_quo;
        end
      end
      S_GADD: begin
        if (axis == 2'd0) begin
          gacc <= gsum;
          axis <= 2'd1;
        end else begin
          term <= gsum;
        end
      end
      S_SADD: begin
        gacc <= gacc + prod[31:0];
        axis <= axis + 2'd1;
      end
      S_WSAT: dens <= (|prod[63:48]) ? '1 : prod[47:0];
      default: ;
    endcase
  end

  // Output register parts the back end from the downstream stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.status       <= st;
      out_data.global_index <= gacc;
      out_data.density      <= dens;
    end
  end

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_add_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_load && (st != ST_READ) |-> (gacc == '0) && (dens == '0))
    else $error("add result carries nonzero index or density");

  a_item_write_addr: assert property (@(posedge clk) disable iff (rst)
    mem_we && !clearing |-> (mem_addr == addr))
    else $error("counter write outside the current cell");

endmodule

FILE: src/particle_density_grid_binning_unit.sv
// The back end works on one item at a time; the shared multiplier and the bit-serial index
// divider set the read time, the shared multiplier and a counter read-modify-write the add time.
// Reset: synchronous; a clearing pass over all MAX_CELLS_PER_SIDE**3 counters (4096 by default)
// zeroes the counters while in_stall stays high; config writes are taken throughout.
`timescale 1ns / 1ps

module particle_density_grid_binning_unit #(
  parameter int MAX_CELLS_PER_SIDE = pdgb_pkg::MAX_CELLS_PER_SIDE_DEF,
  parameter int COUNT_WIDTH        = pdgb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdgb_pkg::PADDR_W-1:0]  paddr,
  input  logic [pdgb_pkg::PDATA_W-1:0]  pwdata,
  output logic [pdgb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pdgb_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdgb_pkg::out_item_t           out_data
);
  import pdgb_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     full;
  logic     not_empty;
  logic     push;
  logic     pop;
  logic     clearing;
  entry_t   entry;
  entry_t   head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_per_side <= 5'd16;
      cfg.inv_cell_size  <= 24'd65536;
      cfg.origin_x       <= '0;
      cfg.origin_y       <= '0;
      cfg.origin_z       <= '0;
      cfg.cell_weight    <= 32'd65536;
      cfg.row_stride     <= 16'd16;
      cfg.plane_stride   <= 32'd256;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CELLS_PER_SIDE: cfg.cells_per_side <= pwdata[4:0];
        REG_INV_CELL_SIZE:  cfg.inv_cell_size  <= pwdata[23:0];
        REG_ORIGIN_X:       cfg.origin_x       <= pwdata;
        REG_ORIGIN_Y:       cfg.origin_y       <= pwdata;
        REG_ORIGIN_Z:       cfg.origin_z       <= pwdata;
        REG_CELL_WEIGHT:    cfg.cell_weight    <= pwdata;
        REG_ROW_STRIDE:     cfg.row_stride     <= pwdata[15:0];
        REG_PLANE_STRIDE:   cfg.plane_stride   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CELLS_PER_SIDE: prdata = 32'(cfg.cells_per_side);
      REG_INV_CELL_SIZE:  prdata = 32'(cfg.inv_cell_size);
      REG_ORIGIN_X:       prdata = cfg.origin_x;
      REG_ORIGIN_Y:       prdata = cfg.origin_y;
      REG_ORIGIN_Z:       prdata = cfg.origin_z;
      REG_CELL_WEIGHT:    prdata = cfg.cell_weight;
      REG_ROW_STRIDE:     prdata = 32'(cfg.row_stride);
      REG_PLANE_STRIDE:   prdata = cfg.plane_stride;
      default:            prdata = '0;
    endcase
  end

  pdgb_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg      (cfg),
    .full     (full),
    .clearing (clearing),
    .push     (push),
    .entry    (entry)
  );

  pdgb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (entry),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  pdgb_back #(
    .MAX_SIDE (MAX_CELLS_PER_SIDE),
    .COUNT_W  (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (not_empty),
    .q_entry   (head),
    .q_pop     (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
